### rtl/core/msadpcm_pkg.sv
// Shared types, constants and coefficient tables of the ADPCM block decoder.
package msadpcm_pkg;

  localparam int DEF_MAX_BLOCK_BYTES = 8192;
  localparam int DEF_FQ_DEPTH        = 2;
  localparam int DEF_OQ_DEPTH        = 4;
  localparam int CHANNEL_COUNT       = 2;
  localparam int NCH                 = 2;
  localparam int HDR_BYTES           = 7;
  localparam int MIN_BLOCK_BYTES     = 8;
  localparam int CFG_W               = 14;

  // configuration register indexes
  localparam logic REG_STEREO = 1'b0;
  localparam logic REG_BLOCK  = 1'b1;

  localparam logic [CFG_W-1:0] BLOCK_BYTES_RESET = 14'd512;

  // header byte positions
  localparam logic [2:0] HP_PRED    = 3'd0;
  localparam logic [2:0] HP_STEP_LO = 3'd1;
  localparam logic [2:0] HP_STEP_HI = 3'd2;
  localparam logic [2:0] HP_NEW_LO  = 3'd3;
  localparam logic [2:0] HP_NEW_HI  = 3'd4;
  localparam logic [2:0] HP_OLD_LO  = 3'd5;
  localparam logic [2:0] HP_OLD_HI  = 3'd6;

  localparam logic [2:0] PRED_MAX = 3'd6;

  localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
  localparam logic signed [31:0] STEP_MIN   = 32'sd16;
  localparam logic signed [31:0] STEP_MAX   = 32'sh7FFF_FFFF;
  localparam int                 DIV_BIAS   = 255;   // 256 - 1, toward-zero fixup
  localparam int                 DIV_SHIFT  = 8;

  // one queued block byte, already classified
  typedef struct packed {
    logic [7:0] lb;
    logic [7:0] rb;
    logic       st;
    logic       hdr;
    logic [2:0] hpos;
    logic       fin;
  } entry_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               last_in_run;
    logic               last_of_block;
    logic               bad_predictor;
  } result_t;

  function automatic logic signed [10:0] coef_one(input logic [2:0] idx);
    logic signed [10:0] c;
    unique case (idx)
      3'd1:    c = 11'sd512;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd192;
      3'd4:    c = 11'sd240;
      3'd5:    c = 11'sd460;
      3'd6:    c = 11'sd392;
      default: c = 11'sd256;
    endcase
    return c;
  endfunction

  function automatic logic signed [10:0] coef_two(input logic [2:0] idx);
    logic signed [10:0] c;
    unique case (idx)
      3'd1:    c = -11'sd256;
      3'd3:    c = 11'sd64;
      3'd5:    c = -11'sd208;
      3'd6:    c = -11'sd232;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [10:0] adapt_factor(input logic [3:0] nib);
    logic signed [10:0] f;
    unique case (nib)
      4'd4, 4'd12:  f = 11'sd307;
      4'd5, 4'd11:  f = 11'sd409;
      4'd6, 4'd10:  f = 11'sd512;
      4'd7, 4'd9:   f = 11'sd614;
      4'd8:         f = 11'sd768;
      default:      f = 11'sd230;
    endcase
    return f;
  endfunction

endpackage

### rtl/core/ms_adpcm_block_decoder_core.sv
// Top level of the 4-bit ADPCM block decoder: front, byte queue, back and result queue.
// A data byte's first sample passes the byte queue, stage B and the result queue.
// Data bytes take 4 slots in stereo (one per cycle while the result queue has room) and
//   2 in mono; header bytes take 1 slot, the last one 2 (mono) or 4 (stereo) slots.
// A header byte waits for any decode in the pipeline to finish before it writes state.
// Reset (rst, synchronous): mono, 512-byte blocks, position at header, channel state zero.
module ms_adpcm_block_decoder_core
  import msadpcm_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int FQ_DEPTH        = DEF_FQ_DEPTH,
  parameter int OQ_DEPTH        = DEF_OQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  // block byte requests
  input  logic               push,
  output logic               full,
  input  logic [7:0]         left_byte,
  input  logic [7:0]         right_byte,
  // sample requests
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample,
  output logic               channel,
  output logic               last_in_run,
  output logic               last_of_block,
  output logic               bad_predictor
);

  localparam int OCW = $clog2(OQ_DEPTH+1);

  entry_t           f_entry;     // classified byte from the front end
  entry_t           q_entry;     // head of the byte queue
  logic             accept;
  logic             q_empty;
  logic             q_pop;
  logic             res_push;
  result_t          res_in;
  result_t          res_out;
  logic [OCW-1:0]   oq_count;

  // a request is taken whenever the byte queue has a free slot
  assign accept = push && !full;

  msadpcm_front #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .left_byte  (left_byte),
    .right_byte (right_byte),
    .entry      (f_entry)
  );

  // decouples byte intake from the decode pipeline
  msadpcm_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (FQ_DEPTH)
  ) u_byte_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (f_entry),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_entry),
    .empty (q_empty),
    .count ()
  );

  // the back end issues a sample-producing slot only when the result queue has room reserved
  msadpcm_back #(
    .OQ_DEPTH (OQ_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_entry  (q_entry),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .oq_count (oq_count),
    .res_push (res_push),
    .res      (res_in)
  );

  // result queue: holds finished samples while the consumer stalls
  msadpcm_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty),
    .count (oq_count)
  );

  assign sample        = res_out.sample;
  assign channel       = res_out.channel;
  assign last_in_run   = res_out.last_in_run;
  assign last_of_block = res_out.last_of_block;
  assign bad_predictor = res_out.bad_predictor;

endmodule

### rtl/core/msadpcm_fifo.sv
// Small register queue used between the front, back and result sides.
module msadpcm_fifo
  import msadpcm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/core/msadpcm_front.sv
// Front end: configuration registers, block byte position and byte classification.
module msadpcm_front
  import msadpcm_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             accept,
  input  logic [7:0]       left_byte,
  input  logic [7:0]       right_byte,
  output entry_t           entry
);

  localparam int PW = $clog2(MAX_BLOCK_BYTES);
  localparam int LW = $clog2(MAX_BLOCK_BYTES + 1);

  logic             stereo_mode;
  logic [CFG_W-1:0] block_bytes;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    pos_next;
  logic [LW-1:0]    len;
  logic             is_hdr;
  logic             final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode <= 1'b0;
      block_bytes <= BLOCK_BYTES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEREO: stereo_mode <= cfg_data[0];
        REG_BLOCK:  block_bytes <= cfg_data;
        default:    ;
      endcase
    end
  end

  // clamp block length to the supported range
  always_comb begin
    if (32'(block_bytes) < 32'(MIN_BLOCK_BYTES)) begin
      len = LW'(MIN_BLOCK_BYTES);
    end else if (32'(block_bytes) > 32'(MAX_BLOCK_BYTES)) begin
      len = LW'(MAX_BLOCK_BYTES);
    end else begin
      len = LW'(block_bytes);
    end
  end

  assign is_hdr     = (pos < PW'(HDR_BYTES));
  assign final_byte = !is_hdr && (LW'(pos) >= len - LW'(1));
  assign pos_next   = final_byte ? '0 : pos + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  always_comb begin
    entry.lb   = left_byte;
    entry.rb   = right_byte;
    entry.st   = stereo_mode && (CHANNEL_COUNT > 1);
    entry.hdr  = is_hdr;
    entry.hpos = pos[2:0];
    entry.fin  = final_byte;
  end

endmodule

### rtl/core/msadpcm_back.sv
// Back end: slot sequencer, channel state and two-stage nibble decode pipeline.
module msadpcm_back
  import msadpcm_pkg::*;
#(
  parameter int OQ_DEPTH = DEF_OQ_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  entry_t                         q_entry,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [$clog2(OQ_DEPTH+1)-1:0]  oq_count,
  output logic                           res_push,
  output result_t                        res
);

  localparam int CW = $clog2(OQ_DEPTH+1);

  // channel state
  logic [2:0]         pred_sel  [NCH];
  logic signed [31:0] step      [NCH];
  logic signed [15:0] newest    [NCH];
  logic signed [15:0] older     [NCH];
  logic [7:0]         low_hold  [NCH];
  logic               fault     [NCH];

  // sequencer
  logic [1:0]         slot;
  logic               hw_op;
  logic               last_slot;
  logic               ch;
  logic               half;
  logic [7:0]         byte_sel;
  logic [7:0]         hbyte     [NCH];
  logic [3:0]         nib;
  logic               room;
  logic               go;

  // stage A products
  logic signed [15:0] s1;
  logic signed [26:0] p1_c;
  logic signed [26:0] p2_c;
  logic signed [35:0] p3_c;
  logic signed [42:0] p4_c;

  // stage B registers
  logic               b_valid;
  logic               b_dec;
  logic               b_ch;
  logic signed [26:0] b_p1;
  logic signed [26:0] b_p2;
  logic signed [35:0] b_p3;
  logic signed [42:0] b_p4;
  logic signed [15:0] b_s1;
  logic signed [15:0] b_pass;
  logic               b_lir;
  logic               b_lob;
  logic               b_bad;

  // stage B results
  logic signed [27:0] sum;
  logic signed [27:0] sum_b;
  logic signed [27:0] quo;
  logic signed [36:0] pred_w;
  logic signed [15:0] pred;
  logic signed [42:0] st_b;
  logic signed [42:0] st_q;
  logic signed [31:0] step_new;

  // ---------------- sequencer ----------------
  assign hw_op     = q_entry.hdr && (q_entry.hpos != HP_OLD_HI);
  assign last_slot = hw_op ? 1'b1 : (q_entry.st ? (slot == 2'd3) : (slot == 2'd1));
  assign ch        = q_entry.st ? slot[0] : 1'b0;
  assign half      = q_entry.st ? slot[1] : slot[0];
  assign hbyte[0]  = q_entry.lb;
  assign hbyte[1]  = q_entry.rb;
  assign byte_sel  = ch ? q_entry.rb : q_entry.lb;
  assign nib       = half ? byte_sel[3:0] : byte_sel[7:4];
  assign room      = ((CW+1)'(oq_count) + (CW+1)'(b_valid)) < (CW+1)'(OQ_DEPTH);

  always_comb begin
    if (q_empty) begin
      go = 1'b0;
    end else if (q_entry.hdr) begin
      // header writes never overlap a decode in flight
      go = !(b_valid && b_dec) && (hw_op || room);
    end else begin
      go = room && !(b_valid && (b_ch == ch));
    end
  end

  assign q_pop = go && last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (q_pop) begin
      slot <= '0;
    end else if (go) begin
      slot <= slot + 2'd1;
    end
  end

  // ---------------- stage A ----------------
  assign s1   = newest[ch];
  assign p1_c = 27'(s1) * 27'(coef_one(pred_sel[ch]));
  assign p2_c = 27'(older[ch]) * 27'(coef_two(pred_sel[ch]));
  assign p3_c = 36'($signed(nib)) * 36'(step[ch]);
  assign p4_c = 43'(step[ch]) * 43'(adapt_factor(nib));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= go && !hw_op;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      b_dec  <= !q_entry.hdr;
      b_ch   <= ch;
      b_p1   <= p1_c;
      b_p2   <= p2_c;
      b_p3   <= p3_c;
      b_p4   <= p4_c;
      b_s1   <= s1;
      b_pass <= half ? newest[ch] : $signed({byte_sel, low_hold[ch]});
      b_lir  <= last_slot;
      b_lob  <= last_slot && q_entry.fin;
      b_bad  <= fault[ch];
    end
  end

  // ---------------- stage B ----------------
  always_comb begin
    sum    = 28'(b_p1) + 28'(b_p2);
    sum_b  = sum + (sum[27] ? 28'(DIV_BIAS) : 28'sd0);
    quo    = sum_b >>> DIV_SHIFT;
    pred_w = 37'(quo) + 37'(b_p3);
    if (pred_w < 37'(SAMPLE_MIN)) begin
      pred = SAMPLE_MIN;
    end else if (pred_w > 37'(SAMPLE_MAX)) begin
      pred = SAMPLE_MAX;
    end else begin
      pred = pred_w[15:0];
    end
    st_b = b_p4 + (b_p4[42] ? 43'(DIV_BIAS) : 43'sd0);
    st_q = st_b >>> DIV_SHIFT;
    if (st_q < 43'(STEP_MIN)) begin
      step_new = STEP_MIN;
    end else if (st_q > 43'(STEP_MAX)) begin
      step_new = STEP_MAX;
    end else begin
      step_new = st_q[31:0];
    end
  end

  assign res_push          = b_valid;
  assign res.sample        = b_dec ? pred : b_pass;
  assign res.channel       = b_ch;
  assign res.last_in_run   = b_lir;
  assign res.last_of_block = b_lob;
  assign res.bad_predictor = b_bad;

  // ---------------- channel state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        pred_sel[c] <= '0;
        step[c]     <= '0;
        newest[c]   <= '0;
        older[c]    <= '0;
        low_hold[c] <= '0;
        fault[c]    <= 1'b0;
      end
    end else begin
      for (int c = 0; c < NCH; c++) begin
        if (b_valid && b_dec && (b_ch == 1'(c))) begin
          newest[c] <= pred;
          older[c]  <= b_s1;
          step[c]   <= step_new;
        end
        if (go && q_entry.hdr && (slot == 2'd0) && ((c == 0) || q_entry.st)) begin
          unique case (q_entry.hpos)
            HP_PRED: begin
              fault[c]    <= (hbyte[c] > 8'(PRED_MAX));
              pred_sel[c] <= (hbyte[c] > 8'(PRED_MAX)) ? 3'd0 : hbyte[c][2:0];
            end
            HP_STEP_HI: step[c]   <= 32'($signed({hbyte[c], low_hold[c]}));
            HP_NEW_HI:  newest[c] <= $signed({hbyte[c], low_hold[c]});
            HP_OLD_HI:  older[c]  <= $signed({hbyte[c], low_hold[c]});
            default:    low_hold[c] <= hbyte[c];
          endcase
        end
      end
    end
  end

  // ---------------- checks ----------------
  a_no_oq_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (oq_count < CW'(OQ_DEPTH)))
    else $error("result pushed into a full result queue");

  a_hdr_no_decode: assert property (@(posedge clk) disable iff (rst)
    (go && q_entry.hdr) |-> !(b_valid && b_dec))
    else $error("header write collides with decode in flight");

  a_mono_slots: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && !q_entry.st && !hw_op) |-> (slot[1] == 1'b0))
    else $error("mono byte ran past two slots");

  a_step_floor: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_dec) |=> (step[$past(b_ch)] >= STEP_MIN))
    else $error("adapted step below floor");

endmodule

### bench/tb.sv
// Self-checking testbench for the ADPCM block decoder core: directed and random blocks.
module tb;
  import msadpcm_pkg::*;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int     IDLE_PCT      = 25;         // chance of a bubble on either side
  localparam int     SETTLE_CYCLES = 16;         // header bytes give no sample; let them land
  localparam int     PRINT_CAP     = 40;         // keep a broken run's log short
  localparam int     RAND_PHASES   = 10;
  localparam longint STEP_CAP      = 64'h7FFF_FFFF;
  localparam int     TIMEOUT       = 800000;     // far beyond a correct run

  typedef struct packed {
    logic [7:0] lb;
    logic [7:0] rb;
  } byte_pair_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cfg_write  = 1'b0;
  logic               cfg_index  = REG_STEREO;
  logic [CFG_W-1:0]   cfg_data   = '0;
  logic               push       = 1'b0;
  logic [7:0]         left_byte  = 8'h00;
  logic [7:0]         right_byte = 8'h00;
  logic               pop        = 1'b0;
  logic               full;
  logic               empty;
  logic signed [15:0] sample;
  logic               channel;
  logic               last_in_run;
  logic               last_of_block;
  logic               bad_predictor;

  ms_adpcm_block_decoder_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .left_byte    (left_byte),
    .right_byte   (right_byte),
    .empty        (empty),
    .pop          (pop),
    .sample       (sample),
    .channel      (channel),
    .last_in_run  (last_in_run),
    .last_of_block(last_of_block),
    .bad_predictor(bad_predictor)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  byte_pair_t block_stream[$];     // block bytes still to be offered
  result_t    expected_pcm[$];     // samples predicted but not yet popped
  int         errors = 0;
  bit         calm   = 1'b0;       // no bubbles on either side while set
  int         gen_pos;             // byte position as seen by the stimulus generator

  // Decoder mirror: configuration and per-channel state
  bit         mode_stereo;
  int         len_cfg;
  int         pos_now;
  logic [2:0] sel_ch   [2];
  int         step_ch  [2];
  int         newest_ch[2];
  int         older_ch [2];
  logic [7:0] lo_hold  [2];
  bit         fault_ch [2];

  int coef_a  [7]  = '{256, 512, 0, 192, 240, 460, 392};
  int coef_b  [7]  = '{0, -256, 0, 64, 0, -208, -232};
  int gain_tbl[16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                       768, 614, 512, 409, 307, 230, 230, 230};

  task automatic report(input string what);
    if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic reset_model();
    mode_stereo = 1'b0;
    len_cfg     = BLOCK_BYTES_RESET;
    pos_now     = 0;
    gen_pos     = 0;
    for (int c = 0; c < NCH; c++) begin
      sel_ch[c]    = '0;
      step_ch[c]   = 0;
      newest_ch[c] = 0;
      older_ch[c]  = 0;
      lo_hold[c]   = '0;
      fault_ch[c]  = 1'b0;
    end
  endtask

  // out-of-range lengths saturate to the legal window
  function automatic int block_len();
    if (len_cfg < MIN_BLOCK_BYTES) return MIN_BLOCK_BYTES;
    if (len_cfg > DEF_MAX_BLOCK_BYTES) return DEF_MAX_BLOCK_BYTES;
    return len_cfg;
  endfunction

  task automatic load_header(input int ch, input int pos, input logic [7:0] b);
    case (pos[2:0])
      HP_PRED: begin
        // an index above 6 falls back to set 0 and flags the block
        fault_ch[ch] = (b > PRED_MAX);
        sel_ch[ch]   = (b > PRED_MAX) ? 3'd0 : b[2:0];
      end
      HP_STEP_HI: step_ch[ch]   = $signed({b, lo_hold[ch]});
      HP_NEW_HI:  newest_ch[ch] = $signed({b, lo_hold[ch]});
      HP_OLD_HI:  older_ch[ch]  = $signed({b, lo_hold[ch]});
      default:    lo_hold[ch]   = b;
    endcase
  endtask

  // one nibble through the predictor and step adaptation
  function automatic logic signed [15:0] next_sample(input int ch, input logic [3:0] nib);
    longint acc;
    longint stp;
    acc = (longint'(newest_ch[ch]) * coef_a[sel_ch[ch]]
         + longint'(older_ch[ch]) * coef_b[sel_ch[ch]]) / 256;   // truncates toward zero
    acc += longint'($signed(nib)) * step_ch[ch];
    if (acc < -32768) acc = -32768;
    if (acc > 32767) acc = 32767;
    older_ch[ch]  = newest_ch[ch];
    newest_ch[ch] = int'(acc);
    stp = longint'(step_ch[ch]) * gain_tbl[nib] / 256;
    if (stp < 16) stp = 16;
    if (stp > STEP_CAP) stp = STEP_CAP;
    step_ch[ch] = int'(stp);
    return acc[15:0];
  endfunction

  task automatic expect_pcm(input logic signed [15:0] s, input int ch);
    result_t r;
    r.sample        = s;
    r.channel       = ch[0];
    r.last_in_run   = 1'b0;
    r.last_of_block = 1'b0;
    r.bad_predictor = fault_ch[ch];
    expected_pcm.push_back(r);
  endtask

  // Mirror of one accepted block byte: updates state, queues its samples.
  task automatic decode_block_byte(input logic [7:0] lb, input logic [7:0] rb);
    bit      st;
    bit      fin;
    int      first;
    result_t tail;
    st    = mode_stereo;
    fin   = 1'b0;
    first = expected_pcm.size();
    if (pos_now < HDR_BYTES) begin
      load_header(0, pos_now, lb);
      if (st) load_header(1, pos_now, rb);
      if (pos_now == HP_OLD_HI) begin
        // header close: older samples first, then newest
        expect_pcm(older_ch[0][15:0], 0);
        if (st) expect_pcm(older_ch[1][15:0], 1);
        expect_pcm(newest_ch[0][15:0], 0);
        if (st) expect_pcm(newest_ch[1][15:0], 1);
      end
      pos_now++;
    end else begin
      // a shortened length can leave the position past the end: this byte closes it
      fin = (pos_now >= block_len() - 1);
      expect_pcm(next_sample(0, lb[7:4]), 0);
      if (st) expect_pcm(next_sample(1, rb[7:4]), 1);
      expect_pcm(next_sample(0, lb[3:0]), 0);
      if (st) expect_pcm(next_sample(1, rb[3:0]), 1);
      pos_now = fin ? 0 : pos_now + 1;
    end
    if (expected_pcm.size() > first) begin
      tail               = expected_pcm.pop_back();
      tail.last_in_run   = 1'b1;
      tail.last_of_block = fin;
      expected_pcm.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pair(input logic [7:0] lb, input logic [7:0] rb);
    byte_pair_t p;
    p.lb = lb;
    p.rb = rb;
    block_stream.push_back(p);
    if (gen_pos < HDR_BYTES) gen_pos++;
    else if (gen_pos >= block_len() - 1) gen_pos = 0;
    else gen_pos++;
  endtask

  task automatic push_header(input logic [7:0] lp, input logic [15:0] ls, ln, lo,
                             input logic [7:0] rp, input logic [15:0] rs, rn, ro);
    push_pair(lp, rp);
    push_pair(ls[7:0], rs[7:0]);
    push_pair(ls[15:8], rs[15:8]);
    push_pair(ln[7:0], rn[7:0]);
    push_pair(ln[15:8], rn[15:8]);
    push_pair(lo[7:0], ro[7:0]);
    push_pair(lo[15:8], ro[15:8]);
  endtask

  // Mostly sane headers (legal index, modest step) with random content elsewhere.
  function automatic logic [7:0] pick_byte(input int pos);
    if (pos == HP_PRED)
      return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, PRED_MAX))
                                          : 8'($urandom_range(7, 255));
    if (pos == HP_STEP_HI && $urandom_range(0, 99) < 60)
      return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_STEREO) mode_stereo = val[0];
    else len_cfg = val & 32'h3FFF;
  endtask

  // Wait until everything offered was taken and every sample came back,
  // then give trailing header bytes time to settle inside the core.
  task automatic settle();
    while (block_stream.size() != 0 || push || expected_pcm.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued block bytes, mirrors each accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    byte_pair_t nxt;
    logic       go;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) decode_block_byte(left_byte, right_byte);
      // slot is free when nothing is offered or the offer was just taken
      if (!push || !full) begin
        go = (block_stream.size() != 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        if (go) begin
          nxt        = block_stream.pop_front();
          left_byte  <= nxt.lb;
          right_byte <= nxt.rb;
        end
        push <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pops samples with random back-pressure, checks against the mirror
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pcm_monitor
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pcm.size() == 0) begin
          report($sformatf("unexpected sample %0d ch %0d", sample, channel));
        end else begin
          want = expected_pcm.pop_front();
          if (sample !== want.sample)
            report($sformatf("sample %0d, want %0d", sample, want.sample));
          if (channel !== want.channel)
            report($sformatf("channel %0b, want %0b", channel, want.channel));
          if (last_in_run !== want.last_in_run)
            report($sformatf("last_in_run %0b, want %0b", last_in_run, want.last_in_run));
          if (last_of_block !== want.last_of_block)
            report($sformatf("last_of_block %0b, want %0b", last_of_block, want.last_of_block));
          if (bad_predictor !== want.bad_predictor)
            report($sformatf("bad_predictor %0b, want %0b", bad_predictor, want.bad_predictor));
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Hard stop in case the core hangs
  // ---------------------------------------------------------------------------
  initial begin
    #(TIMEOUT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int len;
    int cnt;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Mono at reset config: out-of-range predictor index, full-scale samples,
    // max positive step. Runs of nibble 8 triple the step until it saturates,
    // the samples rail on both clamps along the way.
    push_header(8'd7, 16'h7FFF, 16'h7FFF, 16'h8000,
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    repeat (6) push_pair(8'h88, 8'($urandom_range(0, 255)));
    push_pair(8'h77, 8'($urandom_range(0, 255)));
    push_pair(8'h08, 8'($urandom_range(0, 255)));
    push_pair(8'hF0, 8'($urandom_range(0, 255)));

    // sender holds off here until every sample is back
    settle();
    write_reg(REG_STEREO, 1);
    write_reg(REG_BLOCK, MIN_BLOCK_BYTES);

    // Stereo, shortest block: negative header steps on both sides, index 6 on
    // the left, index 255 on the right; the single data byte ends the block.
    push_header(8'd6, 16'hFFFF, 16'h8000, 16'h7FFF,
                8'd255, 16'h8000, 16'h0000, 16'hFFFF);
    push_pair(8'h7F, 8'hF8);

    // Random phases. Phases end mid-block on purpose so that length and mode
    // changes land inside a block; some phases use out-of-range lengths.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      write_reg(REG_STEREO, (ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(0, 1));
      case (ph)
        2:       len = DEF_MAX_BLOCK_BYTES;
        3:       len = $urandom_range(0, MIN_BLOCK_BYTES - 1);
        5:       len = (1 << CFG_W) - 1;
        7:       len = $urandom_range(DEF_MAX_BLOCK_BYTES + 1, (1 << CFG_W) - 1);
        default: len = $urandom_range(MIN_BLOCK_BYTES, 24);
      endcase
      write_reg(REG_BLOCK, len);
      calm = (ph == 4);      // one long run with no bubbles on either side
      cnt  = (ph == 4) ? 40 : $urandom_range(8, 12);
      for (int k = 0; k < cnt; k++) push_pair(pick_byte(gen_pos), pick_byte(gen_pos));
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
